>>> sv/srt_pkg.sv
// srt_pkg: types and codes shared by the sorted record table core and its cells.
// No dependencies.
package srt_pkg;

	// One stored record
	typedef struct packed {
		logic [15:0] key;
		logic [15:0] carrier;
		logic [15:0] arrive;
		logic [15:0] depart;
	} rec_t;

	// Per-cycle operation broadcast to every cell
	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_ROTATE = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		rec_t     new_rec;
	} cell_ctrl_t;

	// Command codes; the remaining code is ignored
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_EMPTY     = 2'd3
	} status_t;

endpackage

>>> sv/srt_cell.sv
// srt_cell: one slot of the sorted table. Holds a record, compares it with the
// request key and takes its neighbor's record on insert, delete and rotate.
// Depends on srt_pkg.
module srt_cell import srt_pkg::*; #(
	parameter int IDX   = 0,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  logic [CNT_W-1:0] count,
	input  cell_ctrl_t       ctrl,
	input  rec_t             prev_rec,
	input  logic             prev_ge,
	input  rec_t             next_rec,
	input  rec_t             wrap_rec,
	output rec_t             rec,
	output logic             ge,
	output logic             eq
);

	rec_t rec_q;
	logic occ;
	logic at_end;
	logic is_tail;

	// Slot position relative to the fill count
	assign occ     = CNT_W'(IDX) < count;
	assign at_end  = CNT_W'(IDX) == count;
	assign is_tail = CNT_W'(IDX + 1) == count;

	// Key compares against the request; only filled slots take part
	assign ge  = occ && (rec_q.key >= ctrl.new_rec.key);
	assign eq  = occ && (rec_q.key == ctrl.new_rec.key);
	assign rec = rec_q;

	// Insert shifts toward the tail, delete and rotate toward the head
	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INSERT: begin
				if (prev_ge) begin
					rec_q <= prev_rec;
				end else if (ge || at_end) begin
					rec_q <= ctrl.new_rec;
				end
			end
			OP_DELETE: begin
				if (ge) begin
					rec_q <= next_rec;
				end
			end
			OP_ROTATE: begin
				if (is_tail) begin
					rec_q <= wrap_rec;
				end else if (occ) begin
					rec_q <= next_rec;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> sv/sorted_record_table_core.sv
// sorted_record_table_core: bounded table of records in ascending key order,
// built as a chain of srt_cell slots. Depends on srt_pkg and srt_cell.
//
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------------
//  in      | in_valid, in_stall | command, record_key, carrier_code, arrive_time,
//          |                    | depart_time
//  out     | out_valid, out_stall| status, out_key, out_carrier, out_arrive,
//          |                    | out_depart, last
//
// Insert and delete finish in the cycle the word is accepted; their result
// word sits in the output register on the next cycle, and a new word can be
// accepted every cycle. Read-out accepts the word, then rotates the cell chain
// one slot per cycle while the output is not stalled and emits one word per
// filled slot; the input is stalled meanwhile.
// A stalled output word also stalls the input. Reset empties the table.
module sorted_record_table_core import srt_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [15:0] record_key,
	input  logic [15:0] carrier_code,
	input  logic [15:0] arrive_time,
	input  logic [15:0] depart_time,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] out_key,
	output logic [15:0] out_carrier,
	output logic [15:0] out_arrive,
	output logic [15:0] out_depart,
	output logic        last
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_left_q;

	logic             out_valid_q;
	status_t          status_q;
	rec_t             out_rec_q;
	logic             last_q;

	cell_ctrl_t       ctrl;
	rec_t             rec_w [CAPACITY];
	logic [CAPACITY-1:0] ge_w;
	logic [CAPACITY-1:0] eq_w;

	logic acc;
	logic out_free;
	logic full;
	logic found;
	logic rd_step;

	// Handshake
	assign in_stall = (state_q == ST_READ) || (out_valid_q && out_stall);
	assign acc      = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign rd_step  = (state_q == ST_READ) && out_free;

	assign full  = count_q == CNT_W'(CAPACITY);
	assign found = |eq_w;

	// Operation broadcast to the chain
	always_comb begin
		ctrl.op              = OP_HOLD;
		ctrl.new_rec.key     = record_key;
		ctrl.new_rec.carrier = carrier_code;
		ctrl.new_rec.arrive  = arrive_time;
		ctrl.new_rec.depart  = depart_time;
		if (acc) begin
			case (command)
				CMD_INSERT: ctrl.op = full ? OP_HOLD : OP_INSERT;
				CMD_DELETE: ctrl.op = found ? OP_DELETE : OP_HOLD;
				default:    ctrl.op = OP_HOLD;
			endcase
		end else if (rd_step) begin
			ctrl.op = OP_ROTATE;
		end
	end

	// Cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rec_t prev_rec;
		logic prev_ge;
		rec_t next_rec;

		if (i == 0) begin : g_head
			assign prev_rec = ctrl.new_rec;
			assign prev_ge  = 1'b0;
		end else begin : g_body
			assign prev_rec = rec_w[i-1];
			assign prev_ge  = ge_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_rec = rec_w[i];
		end else begin : g_mid
			assign next_rec = rec_w[i+1];
		end

		srt_cell #(
			.IDX   (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk      (clk),
			.count    (count_q),
			.ctrl     (ctrl),
			.prev_rec (prev_rec),
			.prev_ge  (prev_ge),
			.next_rec (next_rec),
			.wrap_rec (rec_w[0]),
			.rec      (rec_w[i]),
			.ge       (ge_w[i]),
			.eq       (eq_w[i])
		);
	end

	// Control: fill count, read-out sequencer, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_left_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.op == OP_INSERT) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.op == OP_DELETE) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (acc) begin
				if (command == CMD_READ && count_q != '0) begin
					state_q   <= ST_READ;
					rd_left_q <= count_q;
				end else if (command == CMD_INSERT || command == CMD_DELETE ||
						command == CMD_READ) begin
					out_valid_q <= 1'b1;
				end
			end else if (rd_step) begin
				out_valid_q <= 1'b1;
				rd_left_q   <= rd_left_q - CNT_W'(1);
				if (rd_left_q == CNT_W'(1)) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	// Output word payload
	always_ff @(posedge clk) begin
		if (acc) begin
			out_rec_q.key     <= record_key;
			out_rec_q.carrier <= '0;
			out_rec_q.arrive  <= '0;
			out_rec_q.depart  <= '0;
			last_q            <= 1'b1;
			case (command)
				CMD_INSERT: status_q <= full ? STS_FULL : STS_OK;
				CMD_DELETE: status_q <= found ? STS_OK : STS_NOT_FOUND;
				default:    status_q <= STS_EMPTY;
			endcase
		end else if (rd_step) begin
			out_rec_q <= rec_w[0];
			status_q  <= STS_OK;
			last_q    <= rd_left_q == CNT_W'(1);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_key     = out_rec_q.key;
	assign out_carrier = out_rec_q.carrier;
	assign out_arrive  = out_rec_q.arrive;
	assign out_depart  = out_rec_q.depart;
	assign last        = last_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	a_read_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (rd_left_q != '0 && rd_left_q <= count_q))
		else $error("read-out counter out of range");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && command == CMD_INSERT && !full) |=>
		(count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow the table");

	a_read_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_step && rd_left_q == CNT_W'(1)) |=> (out_valid_q && last_q && state_q == ST_IDLE))
		else $error("read-out did not end with a last word");
`endif

endmodule
